[src/dtrc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the debounced tach rate counter.
// Used by every module of the block; depends on nothing.
package dtrc_pkg;

    localparam int LEVEL_BITS     = 4;
    localparam int OUT_FIELDS     = 4;
    localparam int HIGH_W         = 8;
    localparam int COUNT_W        = 16;
    localparam int GATE_W         = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_INDEX_W    = 1;

    localparam logic [HIGH_W-1:0]  HIGH_TIME_MAX  = 8'd255;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 16'd65535;
    localparam logic [GATE_W-1:0]  GATE_RESET     = 16'd1000;
    localparam logic [HIGH_W-1:0]  MIN_HIGH_RESET = 8'd4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GATE_TICKS     = 1'b0,
        CFG_MIN_HIGH_TICKS = 1'b1
    } t_cfg_index;

    // Per-tick control from the gate countdown to the channel counters.
    typedef struct packed {
        logic step;        // a tick is being applied this cycle
        logic window_end;  // this tick closes the measurement window
    } t_tick_ctl;

endpackage

[src/dtrc_channel.sv]
`timescale 1ns / 1ps
// One tachometer channel: high-time debounce and saturating pulse count.
// Depends on dtrc_pkg.
module dtrc_channel (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dtrc_pkg::t_tick_ctl          i_ctl,
    input  logic                         i_level,
    input  logic [dtrc_pkg::HIGH_W-1:0]  i_min_high,
    output logic [dtrc_pkg::COUNT_W-1:0] o_count
);

    logic [dtrc_pkg::HIGH_W-1:0]  r_high_time, n_high_time;
    logic [dtrc_pkg::COUNT_W-1:0] r_pulse_count, n_pulse_count;

    always_comb begin
        n_high_time   = r_high_time;
        n_pulse_count = r_pulse_count;
        if (i_level) begin
            if (r_high_time != dtrc_pkg::HIGH_TIME_MAX) begin
                n_high_time = r_high_time + 1'b1;
                // count once, on the step up to the threshold
                if (n_high_time == i_min_high && r_pulse_count != dtrc_pkg::COUNT_MAX) begin
                    n_pulse_count = r_pulse_count + 1'b1;
                end
            end
        end else begin
            n_high_time = '0;
        end
    end

    // count including this tick, for the result of a closing window
    assign o_count = n_pulse_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_time   <= '0;
            r_pulse_count <= '0;
        end else if (i_ctl.step) begin
            r_high_time   <= n_high_time;
            r_pulse_count <= i_ctl.window_end ? '0 : n_pulse_count;
        end
    end

endmodule

[src/dtrc_gate.sv]
`timescale 1ns / 1ps
// Measurement window countdown; flags the tick that closes each window.
// Depends on dtrc_pkg.
module dtrc_gate (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [dtrc_pkg::GATE_W-1:0] i_gate_ticks,
    output dtrc_pkg::t_tick_ctl         o_ctl
);

    logic [dtrc_pkg::GATE_W-1:0] r_remaining, n_remaining;
    logic                        w_expire;

    // a reload of zero wraps here, giving a full 65536-tick window
    assign n_remaining = r_remaining - 1'b1;
    assign w_expire    = (n_remaining == '0);

    assign o_ctl.step       = i_step;
    assign o_ctl.window_end = i_step & w_expire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= dtrc_pkg::GATE_RESET;
        end else if (i_step) begin
            r_remaining <= w_expire ? i_gate_ticks : n_remaining;
        end
    end

endmodule

[src/debounced_tach_rate_counter_core.sv]
`timescale 1ns / 1ps
// Debounced tach rate counter: one tick item per cycle while o_stall is low, four
// pulse rates per window. An accepted tick is registered in the input register; the
// result of a window-closing tick goes from there to the result or skid register.
// A result/skid register pair absorbs a stalled result.
// Reset: synchronous, active low; counters clear, window reloads 1000, registers
// return to gate_ticks 1000 and min_high_ticks 4. Depends on dtrc_pkg.
module debounced_tach_rate_counter_core #(
    parameter int CHANNELS = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [dtrc_pkg::LEVEL_BITS-1:0]      i_tach_levels,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [dtrc_pkg::COUNT_W-1:0]         o_rate_ch0,
    output logic [dtrc_pkg::COUNT_W-1:0]         o_rate_ch1,
    output logic [dtrc_pkg::COUNT_W-1:0]         o_rate_ch2,
    output logic [dtrc_pkg::COUNT_W-1:0]         o_rate_ch3,
    input  logic                                 i_cfg_we,
    input  logic [dtrc_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [dtrc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int NF = dtrc_pkg::OUT_FIELDS;

    typedef logic [dtrc_pkg::COUNT_W-1:0] t_rate;

    logic [dtrc_pkg::GATE_W-1:0]     r_gate_ticks;
    logic [dtrc_pkg::HIGH_W-1:0]     r_min_high;
    logic                            r_in_valid;
    logic [dtrc_pkg::LEVEL_BITS-1:0] r_in_levels;
    logic                            r_out_valid, r_skid_valid;
    t_rate                           r_out [NF];
    t_rate                           r_skid [NF];
    t_rate                           n_result [NF];
    t_rate                           w_count [CHANNELS];
    dtrc_pkg::t_tick_ctl             w_ctl;
    logic                            w_in_accept, w_pop, w_push;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate_ticks <= dtrc_pkg::GATE_RESET;
            r_min_high   <= dtrc_pkg::MIN_HIGH_RESET;
        end else if (i_cfg_we) begin
            unique case (dtrc_pkg::t_cfg_index'(i_cfg_index))
                dtrc_pkg::CFG_GATE_TICKS:     r_gate_ticks <= i_cfg_data;
                dtrc_pkg::CFG_MIN_HIGH_TICKS: r_min_high   <= i_cfg_data[dtrc_pkg::HIGH_W-1:0];
            endcase
        end
    end

    // hold the input while the skid is full or a tick's result could find no slot
    assign o_stall     = r_skid_valid | (r_out_valid & r_in_valid & i_stall);
    assign w_in_accept = i_valid & ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_levels <= i_tach_levels;
        end
    end

    dtrc_gate u_gate (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (r_in_valid),
        .i_gate_ticks (r_gate_ticks),
        .o_ctl        (w_ctl)
    );

    for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_ch
        logic w_level;
        if (ch < dtrc_pkg::LEVEL_BITS) begin : g_pin
            assign w_level = r_in_levels[ch];
        end else begin : g_nopin
            assign w_level = 1'b0;
        end
        dtrc_channel u_channel (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_level    (w_level),
            .i_min_high (r_min_high),
            .o_count    (w_count[ch])
        );
    end

    for (genvar f = 0; f < NF; f++) begin : g_field
        if (f < CHANNELS) begin : g_used
            assign n_result[f] = w_count[f];
        end else begin : g_unused
            assign n_result[f] = '0;
        end
    end

    assign w_push = w_ctl.window_end;
    assign w_pop  = r_out_valid & ~i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // input is held while the skid is full, so no push here
            if (w_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_push) begin
            if (r_out_valid && !w_pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_out <= r_skid;
            end
        end else if (w_push) begin
            if (r_out_valid && !w_pop) begin
                r_skid <= n_result;
            end else begin
                r_out <= n_result;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_rate_ch0 = r_out[0];
    assign o_rate_ch1 = r_out[1];
    assign o_rate_ch2 = r_out[2];
    assign o_rate_ch3 = r_out[3];

endmodule

[src/dtrc_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the debounced tach rate counter, bound to the top level.
// Depends on dtrc_pkg and debounced_tach_rate_counter_core.
module dtrc_checker #(
    parameter int CHANNELS = 4
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_stall,
    input logic                             o_valid,
    input logic                             i_stall,
    input logic [dtrc_pkg::COUNT_W-1:0]     o_rate_ch0,
    input logic [dtrc_pkg::COUNT_W-1:0]     o_rate_ch1,
    input logic [dtrc_pkg::COUNT_W-1:0]     o_rate_ch2,
    input logic [dtrc_pkg::COUNT_W-1:0]     o_rate_ch3
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rate_ch0) && $stable(o_rate_ch1)
            && $stable(o_rate_ch2) && $stable(o_rate_ch3))
        else $error("stalled result changed");

    // the input is only held back while a result is waiting
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with no result pending");

    // reset empties the result side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("result valid after reset");

    // with fewer than four channels, channel 3 reports zero
    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (CHANNELS < 4) |-> o_rate_ch3 == '0)
        else $error("absent channel reported pulses");

endmodule

bind debounced_tach_rate_counter_core dtrc_checker #(.CHANNELS(CHANNELS)) u_dtrc_checker (.*);
